### rtl/lslf_pkg.sv
package lslf_pkg;

    localparam int DEF_MAX_POINTS = 64;
    localparam int DEF_COORD_BITS = 10;

    // quotient carries one fraction bit beyond q16.16 for rounding
    localparam int FRAC_BITS = 17;
    localparam int QUO_W     = 34;
    localparam int FIX_W     = 32;

    typedef logic signed [FIX_W-1:0] t_fixed;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL_A,
        ST_MUL_B,
        ST_MUL_C,
        ST_MUL_D,
        ST_DIV_S,
        ST_MUL_E,
        ST_MUL_F,
        ST_DIV_O,
        ST_OUT
    } t_state;

    localparam logic [QUO_W-1:0] POS_LIMIT = {2'b00, 32'h7FFF_FFFF};
    localparam logic [QUO_W-1:0] NEG_LIMIT = {2'b00, 32'h8000_0000};

    // halves away from zero, then sign and saturate
    function automatic t_fixed round_sat(input logic [QUO_W-1:0] quo,
                                         input logic ovf,
                                         input logic neg);
        logic [QUO_W:0]   inc;
        logic [QUO_W-1:0] mag;
        t_fixed           res;
        inc = {1'b0, quo} + {{QUO_W{1'b0}}, 1'b1};
        mag = inc[QUO_W:1];
        if (!neg) begin
            if (ovf || (mag > POS_LIMIT)) begin
                res = t_fixed'(POS_LIMIT[FIX_W-1:0]);
            end else begin
                res = t_fixed'(mag[FIX_W-1:0]);
            end
        end else begin
            if (ovf || (mag > NEG_LIMIT)) begin
                res = t_fixed'(NEG_LIMIT[FIX_W-1:0]);
            end else begin
                res = t_fixed'({FIX_W{1'b0}} - mag[FIX_W-1:0]);
            end
        end
        return res;
    endfunction

endpackage

### rtl/lslf_acc.sv
module lslf_acc import lslf_pkg::*; #(
    parameter int MAX_POINTS = DEF_MAX_POINTS,
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int CNT_W      = 7,
    parameter int SX_W       = 17,
    parameter int SXX_W      = 27
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_add,
    input  logic                  i_clr,
    input  logic [COORD_BITS-1:0] i_x,
    input  logic [COORD_BITS-1:0] i_y,
    output logic [CNT_W-1:0]      o_count,
    output logic [SX_W-1:0]       o_sum_x,
    output logic [SX_W-1:0]       o_sum_y,
    output logic [SXX_W-1:0]      o_sum_xx,
    output logic [SXX_W-1:0]      o_sum_xy
);

    logic [CNT_W-1:0]        r_count;
    logic [SX_W-1:0]         r_sum_x;
    logic [SX_W-1:0]         r_sum_y;
    logic [SXX_W-1:0]        r_sum_xx;
    logic [SXX_W-1:0]        r_sum_xy;
    logic [2*COORD_BITS-1:0] xx;
    logic [2*COORD_BITS-1:0] xy;
    logic                    room;

    assign xx   = i_x * i_x;
    assign xy   = i_x * i_y;
    assign room = (r_count < CNT_W'(MAX_POINTS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_count  <= '0;
            r_sum_x  <= '0;
            r_sum_y  <= '0;
            r_sum_xx <= '0;
            r_sum_xy <= '0;
        end else if (i_add && room) begin
            r_count  <= r_count + CNT_W'(1);
            r_sum_x  <= r_sum_x + SX_W'(i_x);
            r_sum_y  <= r_sum_y + SX_W'(i_y);
            r_sum_xx <= r_sum_xx + SXX_W'(xx);
            r_sum_xy <= r_sum_xy + SXX_W'(xy);
        end
    end

    assign o_count  = r_count;
    assign o_sum_x  = r_sum_x;
    assign o_sum_y  = r_sum_y;
    assign o_sum_xx = r_sum_xx;
    assign o_sum_xy = r_sum_xy;

endmodule

### rtl/lslf_mul.sv
module lslf_mul import lslf_pkg::*; #(
    parameter int A_W = 27,
    parameter int B_W = 17
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [A_W-1:0]     i_a,
    input  logic [B_W-1:0]     i_b,
    output logic               o_done,
    output logic [A_W+B_W-1:0] o_prod
);

    localparam int P_W = A_W + B_W;
    localparam int C_W = (B_W > 1) ? $clog2(B_W) : 1;

    logic           r_busy;
    logic           r_done;
    logic [C_W-1:0] r_cnt;
    logic [P_W-1:0] r_mcand;
    logic [B_W-1:0] r_mplier;
    logic [P_W-1:0] r_prod;

    // shift-and-add, one multiplier bit a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + C_W'(1);
                if (r_cnt == C_W'(B_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mcand  <= P_W'(i_a);
            r_mplier <= i_b;
            r_prod   <= '0;
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                r_prod <= r_prod + r_mcand;
            end
            r_mcand  <= {r_mcand[P_W-2:0], 1'b0};
            r_mplier <= {1'b0, r_mplier[B_W-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;

endmodule

### rtl/lslf_div.sv
module lslf_div import lslf_pkg::*; #(
    parameter int N_W = 44,
    parameter int D_W = 34
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [N_W-1:0]   i_num,
    input  logic [D_W-1:0]   i_den,
    output logic             o_done,
    output logic [QUO_W-1:0] o_quo,
    output logic             o_ovf
);

    localparam int STEPS = N_W + FRAC_BITS;
    localparam int C_W   = $clog2(STEPS);

    logic             r_busy;
    logic             r_done;
    logic [C_W-1:0]   r_cnt;
    logic [N_W-1:0]   r_num;
    logic [D_W-1:0]   r_rem;
    logic [QUO_W-1:0] r_quo;
    logic             r_ovf;
    logic [D_W:0]     rem2;
    logic             fits;
    logic [D_W:0]     rem_nx;

    // restoring division, one quotient bit a cycle; the numerator runs out
    // into zeros for the fraction bits
    assign rem2   = {r_rem, r_num[N_W-1]};
    assign fits   = (rem2 >= {1'b0, i_den});
    assign rem_nx = fits ? (rem2 - {1'b0, i_den}) : rem2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + C_W'(1);
                if (r_cnt == C_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_quo <= '0;
            r_ovf <= 1'b0;
        end else if (r_busy) begin
            r_num <= {r_num[N_W-2:0], 1'b0};
            r_rem <= rem_nx[D_W-1:0];
            r_quo <= {r_quo[QUO_W-2:0], fits};
            // a bit shifted out the top means far past saturation
            r_ovf <= r_ovf | r_quo[QUO_W-1];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_ovf  = r_ovf;

endmodule

### rtl/least_squares_line_fit_unit.sv
// item without last_point: taken, no result
// item with last_point: taken, then input stalls while the fit is computed, and
// longer while the previous result still waits in the output register; the fit
// uses the serial multiplier (one bit a cycle, six products, two for a degenerate
// set) and serial divider (two quotients, none for a degenerate set)
// reset: count and sums cleared, no result pending, ready in the next cycle
module least_squares_line_fit_unit import lslf_pkg::*; #(
    parameter int MAX_POINTS = DEF_MAX_POINTS,
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [COORD_BITS-1:0] i_cur_coord,
    input  logic [COORD_BITS-1:0] i_ref_coord,
    input  logic                  i_last_point,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic signed [31:0]    o_scale_fixed,
    output logic signed [31:0]    o_offset_fixed,
    output logic                  o_fit_valid
);

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int SX_W  = COORD_BITS + CNT_W;
    localparam int SXX_W = 2 * COORD_BITS + CNT_W;
    localparam int PW    = SXX_W + SX_W;
    localparam int DET_W = SXX_W + CNT_W;

    t_state r_state;
    t_state n_state;

    logic [CNT_W-1:0] count;
    logic [SX_W-1:0]  sum_x;
    logic [SX_W-1:0]  sum_y;
    logic [SXX_W-1:0] sum_xx;
    logic [SXX_W-1:0] sum_xy;

    logic             in_acc;
    logic             acc_clr;
    logic             out_load;
    logic             mul_start;
    logic [SXX_W-1:0] mul_a;
    logic [SX_W-1:0]  mul_b;
    logic             mul_done;
    logic [PW-1:0]    prod;
    logic             div_start;
    logic             div_done;
    logic [QUO_W-1:0] div_quo;
    logic             div_ovf;

    logic [PW-1:0]    r_pa;
    logic [PW-1:0]    r_pc;
    logic [DET_W-1:0] r_det;
    logic             r_neg;
    t_fixed           r_res_scale;
    t_fixed           r_res_offset;
    logic             r_res_fit;

    logic             r_out_valid;
    t_fixed           r_scale_out;
    t_fixed           r_offset_out;
    logic             r_fit_out;

    logic [PW:0]      det_full;
    logic             det_pos;
    logic             num_ge;
    logic [PW-1:0]    num_mag;

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;

    lslf_acc #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS),
        .CNT_W      (CNT_W),
        .SX_W       (SX_W),
        .SXX_W      (SXX_W)
    ) u_acc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_add    (in_acc),
        .i_clr    (acc_clr),
        .i_x      (i_cur_coord),
        .i_y      (i_ref_coord),
        .o_count  (count),
        .o_sum_x  (sum_x),
        .o_sum_y  (sum_y),
        .o_sum_xx (sum_xx),
        .o_sum_xy (sum_xy)
    );

    lslf_mul #(
        .A_W (SXX_W),
        .B_W (SX_W)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (prod)
    );

    lslf_div #(
        .N_W (PW),
        .D_W (DET_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num_mag),
        .i_den   (r_det),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_ovf   (div_ovf)
    );

    // det = n*sxx - sx*sx, and numerator = first product - second product
    assign det_full = {1'b0, r_pa} - {1'b0, prod};
    assign det_pos  = !det_full[PW] && (|det_full[PW-1:0]);
    assign num_ge   = (r_pc >= prod);
    assign num_mag  = num_ge ? (r_pc - prod) : (prod - r_pc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        acc_clr   = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && i_last_point) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                mul_start = 1'b1;
                mul_a     = sum_xx;
                mul_b     = SX_W'(count);
                n_state   = ST_MUL_A;
            end
            ST_MUL_A: begin
                if (mul_done) begin
                    mul_start = 1'b1;
                    mul_a     = SXX_W'(sum_x);
                    mul_b     = sum_x;
                    n_state   = ST_MUL_B;
                end
            end
            ST_MUL_B: begin
                if (mul_done) begin
                    if (det_pos) begin
                        mul_start = 1'b1;
                        mul_a     = sum_xy;
                        mul_b     = SX_W'(count);
                        n_state   = ST_MUL_C;
                    end else begin
                        n_state = ST_OUT;
                    end
                end
            end
            ST_MUL_C: begin
                if (mul_done) begin
                    mul_start = 1'b1;
                    mul_a     = SXX_W'(sum_y);
                    mul_b     = sum_x;
                    n_state   = ST_MUL_D;
                end
            end
            ST_MUL_D: begin
                if (mul_done) begin
                    div_start = 1'b1;
                    n_state   = ST_DIV_S;
                end
            end
            ST_DIV_S: begin
                if (div_done) begin
                    mul_start = 1'b1;
                    mul_a     = sum_xx;
                    mul_b     = sum_y;
                    n_state   = ST_MUL_E;
                end
            end
            ST_MUL_E: begin
                if (mul_done) begin
                    mul_start = 1'b1;
                    mul_a     = sum_xy;
                    mul_b     = sum_x;
                    n_state   = ST_MUL_F;
                end
            end
            ST_MUL_F: begin
                if (mul_done) begin
                    div_start = 1'b1;
                    n_state   = ST_DIV_O;
                end
            end
            ST_DIV_O: begin
                if (div_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                // wait for the output register to free up
                if (!r_out_valid || !i_out_stall) begin
                    out_load = 1'b1;
                    acc_clr  = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_MUL_A: begin
                if (mul_done) begin
                    r_pa <= prod;
                end
            end
            ST_MUL_B: begin
                if (mul_done) begin
                    r_det     <= det_full[DET_W-1:0];
                    r_res_fit <= det_pos;
                    if (!det_pos) begin
                        r_res_scale  <= '0;
                        r_res_offset <= '0;
                    end
                end
            end
            ST_MUL_C: begin
                if (mul_done) begin
                    r_pc <= prod;
                end
            end
            ST_MUL_D: begin
                if (mul_done) begin
                    r_neg <= !num_ge;
                end
            end
            ST_DIV_S: begin
                if (div_done) begin
                    r_res_scale <= round_sat(div_quo, div_ovf, r_neg);
                end
            end
            ST_MUL_E: begin
                if (mul_done) begin
                    r_pc <= prod;
                end
            end
            ST_MUL_F: begin
                if (mul_done) begin
                    r_neg <= !num_ge;
                end
            end
            ST_DIV_O: begin
                if (div_done) begin
                    r_res_offset <= round_sat(div_quo, div_ovf, r_neg);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_scale_out  <= r_res_scale;
            r_offset_out <= r_res_offset;
            r_fit_out    <= r_res_fit;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_scale_fixed  = r_scale_out;
    assign o_offset_fixed = r_offset_out;
    assign o_fit_valid    = r_fit_out;

endmodule
